/* rtl/msie_pkg.sv */
package msie_pkg;

   localparam int MemWordsDefault     = 4096;
   localparam int ProgramLinesDefault = 1024;

   localparam logic [31:0] SP_RESET = 32'd2147479548;
   localparam logic [4:0]  SP_INDEX = 5'd29;

   localparam logic [3:0] KIND_ADD     = 4'd0;
   localparam logic [3:0] KIND_SUB     = 4'd1;
   localparam logic [3:0] KIND_MUL     = 4'd2;
   localparam logic [3:0] KIND_SLT     = 4'd3;
   localparam logic [3:0] KIND_ADDI    = 4'd4;
   localparam logic [3:0] KIND_BEQ     = 4'd5;
   localparam logic [3:0] KIND_BNE     = 4'd6;
   localparam logic [3:0] KIND_J       = 4'd7;
   localparam logic [3:0] KIND_LI      = 4'd8;
   localparam logic [3:0] KIND_LW      = 4'd9;
   localparam logic [3:0] KIND_SW      = 4'd10;
   localparam logic [3:0] KIND_COUNTED = 4'd11;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_ADDR = 2'd1;
   localparam logic [1:0] STAT_HALTED   = 2'd2;

   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 88;

   typedef struct packed {
      logic accept;
      logic exec;
      logic commit;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_room;
   } dp_status_type;

   function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
      logic [31:0] value;
      value = (idx == SP_INDEX) ? SP_RESET : 32'd0;
      return value;
   endfunction

endpackage

/* rtl/msie_ctrl.sv */
module msie_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  msie_pkg::dp_status_type stat,
   output msie_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_WB    = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            if (stat.out_room) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/msie_datapath.sv */
module msie_datapath #(
   parameter int MEM_WORDS     = msie_pkg::MemWordsDefault,
   parameter int PROGRAM_LINES = msie_pkg::ProgramLinesDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [msie_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [msie_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [msie_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  msie_pkg::cmd_type                cmd,
   output msie_pkg::dp_status_type          stat
);

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int LW = $clog2(PROGRAM_LINES + 1);
   localparam int TW = (LW + 1 > 11) ? LW + 1 : 11;
   localparam logic [31:0]   MEM_LIMIT = 32'(MEM_WORDS);
   localparam logic [AW-1:0] MEM_LAST  = AW'(MEM_WORDS - 1);
   localparam logic [TW-1:0] LINE_MAX  = TW'(PROGRAM_LINES);

   logic [3:0]  in_kind;
   logic        in_literal;
   logic [4:0]  in_r1;
   logic [4:0]  in_r2;
   logic [4:0]  in_r3;
   logic [31:0] in_imm;
   logic [9:0]  in_label;
   logic [4:0]  sel_b;

   logic [3:0]  kind_ff;
   logic        literal_ff;
   logic [4:0]  r1_ff;
   logic [31:0] imm_ff;
   logic [9:0]  label_ff;
   logic [31:0] a_ff;
   logic [31:0] b_ff;

   logic [31:0] rf_mem_ff [32];
   logic [31:0] rf_valid_ff;
   logic [31:0] dm_mem_ff [MEM_WORDS];
   logic [31:0] dm_rd_ff;
   logic [AW-1:0] clr_cnt_ff;

   logic [31:0] alu_ff;
   logic [31:0] prod_ff;
   logic        take_ff;
   logic        addr_ok_ff;
   logic [AW-1:0] addr_ff;

   logic [LW-1:0] line_ff;
   logic          halted_ff;
   logic [31:0]   counts_ff [11];

   logic                         rsp_tvalid_ff;
   logic [msie_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic [31:0] alu_calc;
   logic        take_calc;
   logic [31:0] sum;
   logic [31:0] idx;
   logic        addr_ok_calc;
   logic [AW-1:0] addr_calc;

   logic          is_lsw;
   logic          bad;
   logic          writes;
   logic          counted;
   logic          live;
   logic [31:0]   wval;
   logic [31:0]   cnt_cur;
   logic [31:0]   cnt_inc;
   logic [TW-1:0] line_t;
   logic [TW-1:0] label_t;
   logic [LW-1:0] next_line;
   logic [1:0]    out_status;
   logic [31:0]   out_count;
   logic          dm_we;
   logic [AW-1:0] dm_waddr;
   logic [31:0]   dm_wdata;

   assign in_kind    = req_tuser[3:0];
   assign in_literal = req_tuser[4];
   assign in_r1      = req_tdata[4:0];
   assign in_r2      = req_tdata[9:5];
   assign in_r3      = req_tdata[14:10];
   assign in_imm     = req_tdata[46:15];
   assign in_label   = req_tdata[56:47];

   // Branches and stores need the first register on the second read port.
   assign sel_b = (in_kind inside {msie_pkg::KIND_BEQ, msie_pkg::KIND_BNE,
                                   msie_pkg::KIND_SW}) ? in_r1 : in_r3;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= in_kind;
         literal_ff <= in_literal;
         r1_ff      <= in_r1;
         imm_ff     <= in_imm;
         label_ff   <= in_label;
         a_ff <= rf_valid_ff[in_r2] ? rf_mem_ff[in_r2] : msie_pkg::rf_reset_value(in_r2);
         b_ff <= rf_valid_ff[sel_b] ? rf_mem_ff[sel_b] : msie_pkg::rf_reset_value(sel_b);
      end
      if (live && writes) begin
         rf_mem_ff[r1_ff] <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (live && writes) begin
         rf_valid_ff[r1_ff] <= 1'b1;
      end
   end

   always_comb begin
      alu_calc = 32'd0;
      case (kind_ff)
         msie_pkg::KIND_ADD:  alu_calc = a_ff + b_ff;
         msie_pkg::KIND_SUB:  alu_calc = a_ff - b_ff;
         msie_pkg::KIND_SLT:  alu_calc = {31'd0, $signed(a_ff) < $signed(b_ff)};
         msie_pkg::KIND_ADDI: alu_calc = a_ff + imm_ff;
         msie_pkg::KIND_LI:   alu_calc = imm_ff;
         default:             alu_calc = 32'd0;
      endcase
   end

   always_comb begin
      take_calc = 1'b0;
      case (kind_ff)
         msie_pkg::KIND_BEQ: take_calc = (b_ff == a_ff);
         msie_pkg::KIND_BNE: take_calc = (b_ff != a_ff);
         msie_pkg::KIND_J:   take_calc = 1'b1;
         default:            take_calc = 1'b0;
      endcase
   end

   assign sum = a_ff + imm_ff;
   assign idx = literal_ff ? imm_ff : {2'b00, sum[31:2]};
   assign addr_ok_calc = literal_ff ? (!imm_ff[31] && imm_ff < MEM_LIMIT)
                                    : (!sum[31] && sum[1:0] == 2'b00 &&
                                       {2'b00, sum[31:2]} < MEM_LIMIT);
   assign addr_calc = addr_ok_calc ? idx[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         alu_ff     <= alu_calc;
         prod_ff    <= a_ff * b_ff;
         take_ff    <= take_calc;
         addr_ok_ff <= addr_ok_calc;
         addr_ff    <= addr_calc;
      end
   end

   assign dm_we    = cmd.clear_step || (live && kind_ff == msie_pkg::KIND_SW && addr_ok_ff);
   assign dm_waddr = cmd.clear_step ? clr_cnt_ff : addr_ff;
   assign dm_wdata = cmd.clear_step ? 32'd0 : b_ff;

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem_ff[dm_waddr] <= dm_wdata;
      end
      if (cmd.exec) begin
         dm_rd_ff <= dm_mem_ff[addr_calc];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign stat.clear_last = (clr_cnt_ff == MEM_LAST);
   assign stat.out_room   = !rsp_tvalid_ff || rsp_tready;

   assign live   = cmd.commit && !halted_ff;
   assign is_lsw = kind_ff inside {msie_pkg::KIND_LW, msie_pkg::KIND_SW};
   assign bad    = is_lsw && !addr_ok_ff;

   always_comb begin
      writes = 1'b0;
      wval   = alu_ff;
      case (kind_ff)
         msie_pkg::KIND_ADD, msie_pkg::KIND_SUB, msie_pkg::KIND_SLT,
         msie_pkg::KIND_ADDI, msie_pkg::KIND_LI: begin
            writes = 1'b1;
         end
         msie_pkg::KIND_MUL: begin
            writes = 1'b1;
            wval   = prod_ff;
         end
         msie_pkg::KIND_LW: begin
            writes = addr_ok_ff;
            wval   = dm_rd_ff;
         end
         default: begin
            writes = 1'b0;
         end
      endcase
   end

   assign cnt_cur = (kind_ff < msie_pkg::KIND_COUNTED) ? counts_ff[kind_ff] : 32'd0;
   assign cnt_inc = (cnt_cur == 32'hFFFF_FFFF) ? cnt_cur : cnt_cur + 32'd1;
   assign counted = (kind_ff < msie_pkg::KIND_COUNTED) && !bad;

   assign line_t  = TW'(line_ff) + TW'(1);
   assign label_t = TW'(label_ff) + TW'(1);
   assign next_line = take_ff ? LW'((label_t > LINE_MAX) ? LINE_MAX : label_t)
                              : LW'((line_t > LINE_MAX) ? LINE_MAX : line_t);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= '0;
         halted_ff <= 1'b0;
         for (int i = 0; i < 11; i++) begin
            counts_ff[i] <= 32'd0;
         end
      end else if (live) begin
         line_ff <= next_line;
         if (bad) begin
            halted_ff <= 1'b1;
         end
         if (counted) begin
            counts_ff[kind_ff] <= cnt_inc;
         end
      end
   end

   assign out_status = bad ? msie_pkg::STAT_BAD_ADDR : msie_pkg::STAT_OK;
   assign out_count  = counted ? cnt_inc : (bad ? cnt_cur : 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (halted_ff) begin
            rsp_tdata_ff <= {5'd0, 32'd0, 32'd0, 5'd0, 1'b0, msie_pkg::STAT_HALTED,
                             11'(line_ff)};
         end else begin
            rsp_tdata_ff <= {5'd0, out_count, writes ? wval : 32'd0,
                             writes ? r1_ff : 5'd0, writes, out_status, 11'(next_line)};
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* rtl/mips_subset_instruction_executor.sv */
// Channel   Direction  Ports                     Payload
// req       in         req_tvalid/tready/tdata/  one decoded instruction
//                      tuser
// rsp       out        rsp_tvalid/tready/tdata   one result per instruction
//
// Each request passes through three steps: register file read, execute with the
// data memory read, then write-back into the output register.
// After reset a clearing pass zeroes the data memory, one word a cycle, and
// req_tready stays low until every word has been cleared.
// Reset is synchronous and active high.
// A result that waits on rsp_tready holds the write-back; the next request
// is accepted once the previous one has been written back.
module mips_subset_instruction_executor #(
   parameter int MEM_WORDS     = msie_pkg::MemWordsDefault,
   parameter int PROGRAM_LINES = msie_pkg::ProgramLinesDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_reg, second_reg, third_reg, immediate, label_line, zero fill
   input  logic [msie_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind, address_literal
   input  logic [msie_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // next_line, status, wrote, write_reg, write_value, kind_count, zero fill
   output logic [msie_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   msie_pkg::cmd_type       cmd;
   msie_pkg::dp_status_type stat;

   msie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   msie_datapath #(
      .MEM_WORDS     (MEM_WORDS),
      .PROGRAM_LINES (PROGRAM_LINES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

/* rtl/msie_checker.sv */
module msie_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [msie_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed while stalled.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("Request accepted while another was in progress.");

   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12:11] == msie_pkg::STAT_HALTED
      |-> !rsp_tdata[13] && rsp_tdata[82:51] == 32'd0)
      else $error("Halted result reports a write or a count.");

   a_no_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[13] |-> rsp_tdata[18:14] == 5'd0 && rsp_tdata[50:19] == 32'd0)
      else $error("Write fields set without a register write.");

endmodule

bind mips_subset_instruction_executor msie_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/mips_subset_instruction_executor_test.sv */
`timescale 1ns / 100ps

module mips_subset_instruction_executor_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1680;
   localparam int MEM_WORDS = msie_pkg::MemWordsDefault;
   localparam int PROGRAM_LINES = msie_pkg::ProgramLinesDefault;
   localparam logic [3:0] KIND_LABEL = msie_pkg::KIND_COUNTED;
   localparam logic [3:0] KIND_UNUSED_TOP = 4'd15;

   typedef struct packed {
      logic [3:0]  kind;
      logic [4:0]  first_reg;
      logic [4:0]  second_reg;
      logic [4:0]  third_reg;
      logic [31:0] immediate;
      logic [9:0]  label_line;
      logic        address_literal;
   } instr_type;

   typedef struct packed {
      logic [10:0] next_line;
      logic [1:0]  status;
      logic        wrote;
      logic [4:0]  write_reg;
      logic [31:0] write_value;
      logic [31:0] kind_count;
   } result_type;

   typedef struct packed {
      instr_type  ins;
      logic       typed;
      result_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [msie_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [msie_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [msie_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   logic [31:0] regs [32];
   logic [31:0] mem_words [MEM_WORDS];
   logic [31:0] op_counts [11];
   int line_counter;
   logic halted;

   result_type expected_results[$];
   int issued = 0;
   int checked_count = 0;
   int mismatches = 0;
   int hold_left = 0;
   logic held_off = 1'b0;
   int quiet_cycles = 0;

   mips_subset_instruction_executor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int clamp_line(int value);
      return (value > PROGRAM_LINES) ? PROGRAM_LINES : value;
   endfunction

   function automatic result_type execute_instruction(instr_type ins);
      result_type res;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] sum;
      longint idx;
      logic addr_ok;
      logic counted;
      int next;
      res = '0;
      if (halted) begin
         res.next_line = line_counter[10:0];
         res.status = msie_pkg::STAT_HALTED;
         return res;
      end
      a = regs[ins.second_reg];
      b = regs[ins.third_reg];
      next = clamp_line(line_counter + 1);
      counted = ins.kind < msie_pkg::KIND_COUNTED;
      case (ins.kind)
         msie_pkg::KIND_ADD: begin
            res.wrote = 1'b1;
            res.write_value = a + b;
         end
         msie_pkg::KIND_SUB: begin
            res.wrote = 1'b1;
            res.write_value = a - b;
         end
         msie_pkg::KIND_MUL: begin
            res.wrote = 1'b1;
            res.write_value = a * b;
         end
         msie_pkg::KIND_SLT: begin
            res.wrote = 1'b1;
            res.write_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         end
         msie_pkg::KIND_ADDI: begin
            res.wrote = 1'b1;
            res.write_value = a + ins.immediate;
         end
         msie_pkg::KIND_BEQ: begin
            if (regs[ins.first_reg] == a) next = clamp_line(int'(ins.label_line) + 1);
         end
         msie_pkg::KIND_BNE: begin
            if (regs[ins.first_reg] != a) next = clamp_line(int'(ins.label_line) + 1);
         end
         msie_pkg::KIND_J: begin
            next = clamp_line(int'(ins.label_line) + 1);
         end
         msie_pkg::KIND_LI: begin
            res.wrote = 1'b1;
            res.write_value = ins.immediate;
         end
         msie_pkg::KIND_LW, msie_pkg::KIND_SW: begin
            if (ins.address_literal) begin
               idx = longint'($signed(ins.immediate));
               addr_ok = 1'b1;
            end else begin
               sum = a + ins.immediate;
               idx = longint'($signed(sum)) / 4;
               addr_ok = (sum[1:0] == 2'b00);
            end
            addr_ok = addr_ok && idx >= 0 && idx < MEM_WORDS;
            if (!addr_ok) begin
               res.status = msie_pkg::STAT_BAD_ADDR;
               halted = 1'b1;
               counted = 1'b0;
               res.kind_count = op_counts[ins.kind];
            end else if (ins.kind == msie_pkg::KIND_LW) begin
               res.wrote = 1'b1;
               res.write_value = mem_words[idx];
            end else begin
               mem_words[idx] = regs[ins.first_reg];
            end
         end
         default: begin
         end
      endcase
      if (res.wrote) begin
         res.write_reg = ins.first_reg;
         regs[ins.first_reg] = res.write_value;
      end
      if (counted) begin
         if (op_counts[ins.kind] != 32'hFFFF_FFFF) op_counts[ins.kind]++;
         res.kind_count = op_counts[ins.kind];
      end
      line_counter = next;
      res.next_line = next[10:0];
      return res;
   endfunction

   function automatic row_type op(logic [3:0] kind, logic [4:0] first_reg,
                                  logic [4:0] second_reg, logic [4:0] third_reg,
                                  logic [31:0] immediate, logic [9:0] label_line,
                                  logic address_literal);
      row_type r;
      r = '0;
      r.ins = '{kind, first_reg, second_reg, third_reg, immediate, label_line, address_literal};
      return r;
   endfunction

   function automatic row_type checked(row_type r, int next_line, logic [1:0] status,
                                       logic wrote, logic [4:0] write_reg,
                                       logic [31:0] write_value, logic [31:0] kind_count);
      r.typed = 1'b1;
      r.want = '{next_line[10:0], status, wrote, write_reg, write_value, kind_count};
      return r;
   endfunction

   function automatic instr_type random_instr();
      instr_type ins;
      int pick;
      int word;
      ins.kind = msie_pkg::KIND_ADD;
      ins.first_reg = 5'($urandom_range(0, 31));
      ins.second_reg = 5'($urandom_range(0, 31));
      ins.third_reg = 5'($urandom_range(0, 31));
      ins.label_line = 10'($urandom_range(0, 1023));
      ins.address_literal = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: ins.immediate = 32'h8000_0000;
         1: ins.immediate = 32'h7FFF_FFFF;
         2: ins.immediate = 32'hFFFF_FFFF;
         3: ins.immediate = 32'h0;
         default: ins.immediate = $urandom;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         case ($urandom_range(0, 5))
            0: ins.kind = msie_pkg::KIND_ADD;
            1: ins.kind = msie_pkg::KIND_SUB;
            2: ins.kind = msie_pkg::KIND_MUL;
            3: ins.kind = msie_pkg::KIND_SLT;
            4: ins.kind = msie_pkg::KIND_ADDI;
            default: ins.kind = msie_pkg::KIND_LI;
         endcase
      end else if (pick < 65) begin
         ins.kind = $urandom_range(0, 1) ? msie_pkg::KIND_LW : msie_pkg::KIND_SW;
         word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_WORDS - 1)
                                            : $urandom_range(0, 31);
         if (ins.address_literal) ins.immediate = 32'(word);
         else ins.immediate = 32'(word * 4) - regs[ins.second_reg];
      end else if (pick < 82) begin
         ins.kind = (pick < 72) ? msie_pkg::KIND_BEQ
                  : (pick < 78) ? msie_pkg::KIND_BNE : msie_pkg::KIND_J;
         if ($urandom_range(0, 1)) ins.second_reg = ins.first_reg;
      end else if (pick < 92) begin
         ins.kind = 4'($urandom_range(KIND_LABEL, KIND_UNUSED_TOP));
      end else begin
         ins.kind = msie_pkg::KIND_LI;
         ins.immediate = $urandom_range(0, 64);
      end
      return ins;
   endfunction

   task automatic issue(row_type r);
      result_type predicted;
      logic steady;
      steady = issued >= 700 && issued < 1000;
      if (!steady && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, r.ins.label_line, r.ins.immediate, r.ins.third_reg,
                    r.ins.second_reg, r.ins.first_reg};
      req_tuser <= {r.ins.address_literal, r.ins.kind};
      do @(posedge clock); while (!req_tready);
      predicted = execute_instruction(r.ins);
      expected_results.insert(expected_results.size(), r.typed ? r.want : predicted);
      issued++;
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result arrived with no instruction pending");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               compare_field("next_line", 32'(want.next_line), 32'(rsp_tdata[10:0]));
               compare_field("status", 32'(want.status), 32'(rsp_tdata[12:11]));
               compare_field("wrote", 32'(want.wrote), 32'(rsp_tdata[13]));
               compare_field("write_reg", 32'(want.write_reg), 32'(rsp_tdata[18:14]));
               compare_field("write_value", want.write_value, rsp_tdata[50:19]);
               compare_field("kind_count", want.kind_count, rsp_tdata[82:51]);
               checked_count++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held_off && checked_count >= 300) begin
            held_off = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (checked_count >= 700 && checked_count < 1000)
                          || $urandom_range(0, 99) >= 13;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      row_type directed[$];
      row_type closing[$];
      row_type r;
      for (int i = 0; i < 32; i++) begin
         regs[i] = (i == msie_pkg::SP_INDEX) ? msie_pkg::SP_RESET : 32'd0;
      end
      for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = 32'd0;
      for (int i = 0; i < 11; i++) op_counts[i] = 32'd0;
      line_counter = 0;
      halted = 1'b0;

      directed = {directed, checked(op(msie_pkg::KIND_LI, 1, 0, 0, 32'h7FFF_FFFF, 0, 0),
                                    1, msie_pkg::STAT_OK, 1, 1, 32'h7FFF_FFFF, 1)};
      directed = {directed, checked(op(msie_pkg::KIND_LI, 2, 0, 0, 32'h8000_0000, 1023, 1),
                                    2, msie_pkg::STAT_OK, 1, 2, 32'h8000_0000, 2)};
      directed = {directed, checked(op(msie_pkg::KIND_ADD, 3, 1, 2, 0, 0, 0),
                                    3, msie_pkg::STAT_OK, 1, 3, 32'hFFFF_FFFF, 1)};
      directed = {directed, checked(op(KIND_LABEL, 31, 31, 31, 32'hFFFF_FFFF, 1023, 1),
                                    4, msie_pkg::STAT_OK, 0, 0, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_SUB, 4, 2, 1, 0, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_MUL, 5, 1, 1, 0, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_SLT, 6, 2, 1, 0, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_SLT, 7, 1, 2, 0, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_ADDI, 0, 0, 0, 32'hFFFF_FFFF, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_ADDI, 31, 1, 0, 32'd1, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_SW, 1, 0, 0, MEM_WORDS - 1, 0, 1)};
      directed = {directed, op(msie_pkg::KIND_LW, 8, 0, 0, MEM_WORDS - 1, 0, 1)};
      directed = {directed, op(msie_pkg::KIND_SW, 2, msie_pkg::SP_INDEX, 0,
                               32'h8000_100C, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_LW, 9, msie_pkg::SP_INDEX, 0,
                               32'h8000_100C, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_LW, 10, 0, 0, 32'd0, 0, 1)};
      directed = {directed, op(msie_pkg::KIND_BEQ, 1, 1, 0, 0, 5, 0)};
      directed = {directed, op(msie_pkg::KIND_BEQ, 1, 2, 0, 0, 100, 0)};
      directed = {directed, op(msie_pkg::KIND_BNE, 1, 1, 0, 0, 200, 0)};
      directed = {directed, op(msie_pkg::KIND_BNE, 1, 2, 0, 0, 1023, 0)};
      directed = {directed, op(KIND_LABEL, 0, 0, 0, 0, 0, 0)};
      directed = {directed, op(KIND_UNUSED_TOP, 0, 0, 0, 0, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_J, 0, 0, 0, 0, 0, 0)};
      directed = {directed, op(msie_pkg::KIND_J, 0, 0, 0, 0, 1023, 0)};
      directed = {directed, op(msie_pkg::KIND_ADD, 11, 0, msie_pkg::SP_INDEX, 0, 0, 0)};

      closing = {closing, op(msie_pkg::KIND_LW, 1, 0, 0, MEM_WORDS, 0, 1)};
      closing = {closing, op(msie_pkg::KIND_LW, 2, 0, 0, 32'hFFFF_FFFF, 0, 1)};
      closing = {closing, op(msie_pkg::KIND_SW, 3, 0, 0, 32'd2, 0, 0)};
      closing = {closing, op(msie_pkg::KIND_ADD, 4, 1, 2, 0, 0, 0)};
      closing = {closing, op(msie_pkg::KIND_J, 0, 0, 0, 0, 1023, 0)};
      closing = {closing, op(KIND_UNUSED_TOP, 0, 0, 0, 0, 0, 0)};

      do @(posedge clock); while (reset);

      foreach (directed[i]) issue(directed[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 500) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_results.size() != 0);
         end
         r = '0;
         r.ins = random_instr();
         issue(r);
      end

      foreach (closing[i]) issue(closing[i]);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (10) @(posedge clock);

      $display("Ran %0d instructions with %0d results checked: %0d loads, %0d stores,",
               issued, checked_count, op_counts[msie_pkg::KIND_LW],
               op_counts[msie_pkg::KIND_SW]);
      $display("%0d branches, then a halt on an address one past the last memory word.",
               op_counts[msie_pkg::KIND_BEQ] + op_counts[msie_pkg::KIND_BNE]);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/msie_pkg.sv
rtl/msie_ctrl.sv
rtl/msie_datapath.sv
rtl/mips_subset_instruction_executor.sv
rtl/msie_checker.sv
test/mips_subset_instruction_executor_test.sv
